[hw/rtl/int_to_base_ascii_top_assert.svh]
// Assertion macros for the integer to text converter checker.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef INT_TO_BASE_ASCII_TOP_ASSERT_SVH
`define INT_TO_BASE_ASCII_TOP_ASSERT_SVH

// Same-cycle implication check.
`define I2B_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2b check failed: same cycle");

// Next-cycle implication check.
`define I2B_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2b check failed: next cycle");

`endif

[hw/rtl/i2b_pkg.sv]
// Package for the integer to text converter: sizes, ASCII codes and shared types.
// Used by every RTL module of the block; depends on nothing.
package i2b_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int DIGIT_SLOTS = 32;
    localparam int RADIX_BITS  = 6;
    localparam int DIGIT_BITS  = 6;
    localparam int CHAR_BITS   = 8;

    localparam int CONV_CYCLES = VALUE_BITS + DIGIT_SLOTS - 1;
    localparam int CNT_BITS    = $clog2(CONV_CYCLES);
    localparam int IDX_BITS    = $clog2(DIGIT_SLOTS);

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] ASCII_A     = 8'h41;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [DIGIT_BITS-1:0] DECIMAL_TEN = DIGIT_BITS'(10);

    typedef struct packed {
        logic                  valid;
        logic                  carry;
        logic [DIGIT_BITS-1:0] digit;
    } t_cell_link;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic                 valid;
        logic [CHAR_BITS-1:0] character;
        logic                 final_char;
    } t_out_word;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] d_ext;
        d_ext = CHAR_BITS'(d);
        if (d < DECIMAL_TEN) begin
            return ASCII_ZERO + d_ext;
        end
        return ASCII_A + d_ext - CHAR_BITS'(DECIMAL_TEN);
    endfunction

endpackage

[hw/rtl/i2b_cell.sv]
// One digit cell of the conversion chain: doubles its digit plus a carry modulo the radix.
// Depends on i2b_pkg.
module i2b_cell
    import i2b_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [RADIX_BITS-1:0] i_radix,
    input  t_cell_link            i_prev,
    output t_cell_link            o_link
);

    logic [DIGIT_BITS-1:0] r_digit;
    logic                  r_carry;
    logic                  r_valid;
    logic [DIGIT_BITS:0]   w_twice;
    logic [DIGIT_BITS:0]   w_diff;
    logic                  w_wrap;

    always_comb begin
        w_twice = {r_digit, i_prev.carry};
        w_diff  = w_twice - {1'b0, i_radix};
        w_wrap  = (w_twice >= {1'b0, i_radix});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
            r_carry <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_digit <= '0;
            r_carry <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_digit <= i_prev.digit;
            r_carry <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_prev.valid;
            if (i_prev.valid) begin
                r_digit <= w_wrap ? w_diff[DIGIT_BITS-1:0] : w_twice[DIGIT_BITS-1:0];
                r_carry <= w_wrap;
            end else begin
                r_carry <= 1'b0;
            end
        end
    end

    assign o_link = '{valid: r_valid, carry: r_carry, digit: r_digit};

endmodule

[hw/rtl/i2b_out.sv]
// Output register for result words, with the stall handshake toward the consumer.
// Depends on i2b_pkg.
module i2b_out
    import i2b_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_out_word            i_load,
    input  logic                 i_stall,
    output logic                 o_free,
    output logic                 o_valid,
    output logic [CHAR_BITS-1:0] o_character,
    output logic                 o_final_char
);

    logic                 r_valid;
    logic [CHAR_BITS-1:0] r_character;
    logic                 r_final_char;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load.valid) begin
            r_character  <= i_load.character;
            r_final_char <= i_load.final_char;
        end
    end

    assign o_valid      = r_valid;
    assign o_character  = r_character;
    assign o_final_char = r_final_char;

endmodule

[hw/rtl/int_to_base_ascii_top.sv]
// Integer to text converter: each accepted item runs through the carry pipeline of the 32 digit
// cells, then an optional minus sign and the digit cells are shifted out one per cycle while the
// output is not stalled.
// Reset sets the radix to 10, empties the output register and leaves the block idle.
module int_to_base_ascii_top
    import i2b_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [RADIX_BITS-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAR_BITS-1:0]  o_character,
    output logic                  o_final_char
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [RADIX_BITS-1:0] r_radix;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [IDX_BITS-1:0]   r_idx, n_idx;
    logic                  r_lead, n_lead;

    t_cell_ctrl            w_ctrl;
    t_cell_link            w_head;
    t_cell_link            w_link [DIGIT_SLOTS];
    t_out_word             w_load;
    logic                  w_free;
    logic                  w_accept;
    logic                  w_skip;
    logic [DIGIT_BITS-1:0] w_top;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_top       = w_link[DIGIT_SLOTS-1].digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_data < RADIX_MIN) begin
                r_radix <= RADIX_MIN;
            end else if (i_cfg_data > RADIX_MAX) begin
                r_radix <= RADIX_MAX;
            end else begin
                r_radix <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_lead  = r_lead;
        w_ctrl  = '{clear: 1'b0, shift: 1'b0};
        w_load  = '{valid: 1'b0, character: ASCII_ZERO, final_char: 1'b0};
        w_skip  = 1'b0;
        w_head  = '{valid: 1'b0, carry: 1'b0, digit: '0};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg        = i_value[VALUE_BITS-1];
                    n_mag        = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_cnt        = '0;
                    w_ctrl.clear = 1'b1;
                    n_state      = S_CONV;
                end
            end
            S_CONV: begin
                w_head.valid = (r_cnt < CNT_BITS'(VALUE_BITS));
                w_head.carry = r_mag[VALUE_BITS-1];
                n_mag        = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(CONV_CYCLES - 1)) begin
                    n_idx   = IDX_BITS'(DIGIT_SLOTS - 1);
                    n_lead  = 1'b1;
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_free) begin
                    w_load  = '{valid: 1'b1, character: ASCII_MINUS, final_char: 1'b0};
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                w_skip = r_lead && (w_top == '0) && (r_idx != '0);
                if (w_skip || w_free) begin
                    w_ctrl.shift = 1'b1;
                    n_idx        = r_idx - 1'b1;
                    if (!w_skip) begin
                        w_load = '{valid: 1'b1, character: digit_char(w_top),
                                   final_char: (r_idx == '0)};
                        n_lead = 1'b0;
                    end
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_lead  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_lead  <= n_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
    end

    for (genvar k = 0; k < DIGIT_SLOTS; k++) begin : g_cell
        i2b_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_radix (r_radix),
            .i_prev  ((k == 0) ? w_head : w_link[(k == 0) ? 0 : k - 1]),
            .o_link  (w_link[k])
        );
    end

    i2b_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_stall      (i_out_stall),
        .o_free       (w_free),
        .o_valid      (o_out_valid),
        .o_character  (o_character),
        .o_final_char (o_final_char)
    );

endmodule

[hw/rtl/i2b_checker.sv]
// Port-level checker for the integer to text converter, bound to the top level.
// Depends on i2b_pkg and the assertion macro header.
`include "int_to_base_ascii_top_assert.svh"

module i2b_checker
    import i2b_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [CHAR_BITS-1:0]  o_character,
    input logic                  o_final_char
);

    logic [CHAR_BITS+1:0] w_out_word;
    logic                 w_char_legal;

    assign w_out_word   = {o_out_valid, o_character, o_final_char};
    assign w_char_legal = (o_character == ASCII_MINUS)
                       || ((o_character >= ASCII_ZERO) && (o_character <= 8'h39))
                       || ((o_character >= ASCII_A) && (o_character <= 8'h5A));

    // A stalled output word holds its value.
    `I2B_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, $stable(w_out_word))

    // An accepted input word keeps the block busy on the following cycle.
    `I2B_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // Every character is a minus sign, a decimal digit or an upper-case letter.
    `I2B_ASSERT_NOW(a_char_legal, o_out_valid, w_char_legal)

    // A minus sign is never the last character of a number.
    `I2B_ASSERT_NOW(a_minus_not_final, o_out_valid && (o_character == ASCII_MINUS), !o_final_char)

endmodule

bind int_to_base_ascii_top i2b_checker u_i2b_checker (.*);
